// File: sv/gmhr_pkg.sv
// Shared types, codes and helpers for the grid move history retrace block.
// Used by grid_move_history_retrace_core; depends on nothing else.
package gmhr_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 16;

  // Command selector codes.
  localparam logic [1:0] FUNC_MOVE   = 2'd0;
  localparam logic [1:0] FUNC_BACK   = 2'd1;
  localparam logic [1:0] FUNC_RETURN = 2'd2;

  // Direction codes; a three-bit request direction with its top bit set is invalid.
  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BWD   = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RETURNED = 3'd1;
  localparam logic [2:0] ST_BAD_DIR  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Register indexes on the configuration port.
  localparam logic REG_START_X = 1'b0;
  localparam logic REG_START_Y = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BT_DATA,
    S_RET_DATA
  } state_e;

  // One stack entry, direction in the lowest bits.
  typedef struct packed {
    logic [CountW-1:0] step_number;
    logic [CoordW-1:0] from_y;
    logic [CoordW-1:0] from_x;
    logic [1:0]        dir;
  } entry_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              step_valid;
    logic [1:0]        step_direction;
    logic [CoordW-1:0] from_x;
    logic [CoordW-1:0] from_y;
    logic [CoordW-1:0] to_x;
    logic [CoordW-1:0] to_y;
    logic [CountW-1:0] step_number;
    logic              at_start;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } xy_t;

  // One cell in the given direction, wrapping at the edge of the grid.
  function automatic xy_t step_pos(input logic [1:0] dir, input logic [CoordW-1:0] x,
                                   input logic [CoordW-1:0] y);
    xy_t r;
    r.x = x;
    r.y = y;
    unique case (dir)
      DIR_FWD:   r.y = y + 1'b1;
      DIR_BWD:   r.y = y - 1'b1;
      DIR_LEFT:  r.x = x - 1'b1;
      default:   r.x = x + 1'b1;
    endcase
    return r;
  endfunction

  // True when a step would leave the signed coordinate range.
  function automatic logic step_overflows(input logic [1:0] dir, input logic [CoordW-1:0] x,
                                          input logic [CoordW-1:0] y);
    logic maxc;
    logic minc;
    logic r;
    maxc = 1'b0;
    minc = 1'b0;
    r = 1'b0;
    unique case (dir)
      DIR_FWD:   r = (y == {1'b0, {(CoordW-1){1'b1}}});
      DIR_BWD:   r = (y == {1'b1, {(CoordW-1){1'b0}}});
      DIR_LEFT:  r = (x == {1'b1, {(CoordW-1){1'b0}}});
      default:   r = (x == {1'b0, {(CoordW-1){1'b1}}});
    endcase
    return r | (maxc & minc);
  endfunction

endpackage

// File: sv/grid_move_history_retrace_core.sv
// Top level of the grid move history retrace block: control, position registers
// and the move stack memory. Depends on gmhr_pkg.
//
// Usage:
// Requests enter on the s_axis channel (tdata: func, direction) and results leave on
// the m_axis channel; tlast marks the final result caused by one request. The start
// position is written over the APB port (start_x at 0x0, start_y at 0x4); a write also
// moves the robot to that coordinate and must only happen while the block is idle.
// A move or a refused request has its result registered in the cycle after acceptance.
// A backtrack first reads the stack memory into the read register, then loads its result.
// A return reads one entry per cycle and emits one reversed step per cycle while the
// receiver takes results; after a backtrack or a return the block accepts no new request
// until its last result has been loaded into the output register.
// The registered read of the stack memory sets the backtrack and return timing.
// Results sit in one output register; the next request is accepted in the same cycle
// the previous result is taken. When the receiver stalls, the output register holds,
// no request is accepted and a running return pauses with its read data held.
// Reset places the robot at (0, 0) with an empty stack and zero step count; stack
// entries are not cleared, since only entries below the stack top are ever read.
module grid_move_history_retrace_core #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // func [1:0], direction [4:2], zero [7:5]
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // status [2:0], step_valid [3], step_direction [5:4],
                                      // from_x [21:6], from_y [37:22], to_x [53:38],
                                      // to_y [69:54], step_number [85:70], at_start [86],
                                      // zero [87]
  output logic        m_axis_tlast,   // last
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TopW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW    = gmhr_pkg::CoordW;

  gmhr_pkg::state_e state_q, state_d;

  logic [CW-1:0]   start_x_q, start_y_q;
  logic [CW-1:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [gmhr_pkg::CountW-1:0] move_count_q, move_count_d;
  logic            returned_q, returned_d;
  logic [TopW-1:0] top_q, top_d;
  logic [TopW-1:0] ret_idx_q, ret_idx_d;

  gmhr_pkg::result_t out_q, out_d;
  logic              out_valid_q;
  logic              out_load;
  logic              out_free;

  // Stack memory with one write and one registered read port.
  gmhr_pkg::entry_t  stack_mem [STACK_DEPTH];
  gmhr_pkg::entry_t  wr_data, rd_data_q;
  logic              wr_en, rd_en;
  logic [AddrW-1:0]  wr_addr, rd_addr;

  // Decoded request and control flags for the next-state logic.
  logic              in_acc;
  logic [1:0]        in_func;
  logic [2:0]        in_dir;
  logic              go_bt, go_ret, ret_more;
  logic              cfg_wr;
  logic [TopW-1:0]   top_dec;
  gmhr_pkg::xy_t     mv_pos, ret_pos;
  gmhr_pkg::entry_t  push_entry;

  assign in_func  = s_axis_tdata[1:0];
  assign in_dir   = s_axis_tdata[4:2];
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == gmhr_pkg::S_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign top_dec  = top_q - 1'b1;
  assign rd_addr  = top_dec[AddrW-1:0];
  assign wr_addr  = top_q[AddrW-1:0];

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == gmhr_pkg::REG_START_Y) begin
      prdata = {{(32-CW){start_y_q[CW-1]}}, start_y_q};
    end else begin
      prdata = {{(32-CW){start_x_q[CW-1]}}, start_x_q};
    end
  end

  assign mv_pos  = gmhr_pkg::step_pos(in_dir[1:0], pos_x_q, pos_y_q);
  assign ret_pos = gmhr_pkg::step_pos(rd_data_q.dir ^ 2'b01, pos_x_q, pos_y_q);

  always_comb begin
    push_entry.dir         = in_dir[1:0];
    push_entry.from_x      = pos_x_q;
    push_entry.from_y      = pos_y_q;
    push_entry.step_number = move_count_q + 1'b1;
  end

  // Datapath and control: stack accesses, position updates and the result word.
  always_comb begin
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    move_count_d = move_count_q;
    returned_d   = returned_q;
    top_d        = top_q;
    ret_idx_d    = ret_idx_q;
    wr_en        = 1'b0;
    wr_data      = push_entry;
    rd_en        = 1'b0;
    go_bt        = 1'b0;
    go_ret       = 1'b0;
    ret_more     = 1'b0;
    out_load     = 1'b0;

    // Refusal form by default: no step, position unchanged.
    out_d                = '0;
    out_d.status         = gmhr_pkg::ST_OK;
    out_d.from_x         = pos_x_q;
    out_d.from_y         = pos_y_q;
    out_d.to_x           = pos_x_q;
    out_d.to_y           = pos_y_q;
    out_d.step_number    = move_count_q;
    out_d.last           = 1'b1;

    unique case (state_q)
      gmhr_pkg::S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          unique case (in_func)
            gmhr_pkg::FUNC_MOVE: begin
              priority if (returned_q) begin
                out_d.status = gmhr_pkg::ST_RETURNED;
              end else if (in_dir[2]) begin
                out_d.status = gmhr_pkg::ST_BAD_DIR;
              end else if (top_q == TopW'(STACK_DEPTH) ||
                           gmhr_pkg::step_overflows(in_dir[1:0], pos_x_q, pos_y_q)) begin
                out_d.status = gmhr_pkg::ST_FULL;
              end else begin
                wr_en                = 1'b1;
                top_d                = top_q + 1'b1;
                move_count_d         = push_entry.step_number;
                pos_x_d              = mv_pos.x;
                pos_y_d              = mv_pos.y;
                out_d.step_valid     = 1'b1;
                out_d.step_direction = in_dir[1:0];
                out_d.to_x           = mv_pos.x;
                out_d.to_y           = mv_pos.y;
                out_d.step_number    = push_entry.step_number;
              end
            end
            gmhr_pkg::FUNC_BACK: begin
              if (top_q == '0) begin
                out_d.status = gmhr_pkg::ST_EMPTY;
              end else begin
                out_load = 1'b0;
                rd_en    = 1'b1;
                top_d    = top_dec;
                go_bt    = 1'b1;
              end
            end
            gmhr_pkg::FUNC_RETURN: begin
              if (returned_q) begin
                out_d.status = gmhr_pkg::ST_RETURNED;
              end else begin
                returned_d = 1'b1;
                // An empty stack gives one plain ok result.
                if (top_q != '0) begin
                  out_load  = 1'b0;
                  rd_en     = 1'b1;
                  top_d     = top_dec;
                  ret_idx_d = TopW'(1);
                  go_ret    = 1'b1;
                end
              end
            end
            default: begin
              out_d.status = gmhr_pkg::ST_BAD_DIR;
            end
          endcase
        end
      end
      gmhr_pkg::S_BT_DATA: begin
        out_load             = 1'b1;
        out_d.step_valid     = 1'b1;
        out_d.step_direction = rd_data_q.dir ^ 2'b01;
        out_d.to_x           = rd_data_q.from_x;
        out_d.to_y           = rd_data_q.from_y;
        out_d.step_number    = rd_data_q.step_number;
        pos_x_d              = rd_data_q.from_x;
        pos_y_d              = rd_data_q.from_y;
      end
      gmhr_pkg::S_RET_DATA: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_d.step_valid     = 1'b1;
          out_d.step_direction = rd_data_q.dir ^ 2'b01;
          out_d.to_x           = ret_pos.x;
          out_d.to_y           = ret_pos.y;
          out_d.step_number    = gmhr_pkg::CountW'(ret_idx_q);
          out_d.last           = (top_q == '0);
          pos_x_d              = ret_pos.x;
          pos_y_d              = ret_pos.y;
          if (top_q != '0) begin
            // Fetch the next older entry while this step goes out.
            rd_en     = 1'b1;
            top_d     = top_dec;
            ret_idx_d = ret_idx_q + 1'b1;
            ret_more  = 1'b1;
          end
        end else begin
          ret_more = 1'b1;
        end
      end
      default: begin
      end
    endcase

    out_d.at_start = (out_d.to_x == start_x_q) && (out_d.to_y == start_y_q);

    // A start write puts the robot there; the user must write only while idle (unchecked).
    if (cfg_wr) begin
      if (paddr[2] == gmhr_pkg::REG_START_X) begin
        pos_x_d = pwdata[CW-1:0];
      end else begin
        pos_y_d = pwdata[CW-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gmhr_pkg::S_IDLE: begin
        if (go_bt) begin
          state_d = gmhr_pkg::S_BT_DATA;
        end else if (go_ret) begin
          state_d = gmhr_pkg::S_RET_DATA;
        end
      end
      gmhr_pkg::S_BT_DATA: begin
        state_d = gmhr_pkg::S_IDLE;
      end
      gmhr_pkg::S_RET_DATA: begin
        if (!ret_more) begin
          state_d = gmhr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gmhr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gmhr_pkg::S_IDLE;
      start_x_q    <= '0;
      start_y_q    <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      move_count_q <= '0;
      returned_q   <= 1'b0;
      top_q        <= '0;
      ret_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      move_count_q <= move_count_d;
      returned_q   <= returned_d;
      top_q        <= top_d;
      ret_idx_q    <= ret_idx_d;
      if (cfg_wr) begin
        if (paddr[2] == gmhr_pkg::REG_START_X) begin
          start_x_q <= pwdata[CW-1:0];
        end else begin
          start_y_q <= pwdata[CW-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {1'b0, out_q.at_start, out_q.step_number, out_q.to_y, out_q.to_x,
                          out_q.from_y, out_q.from_x, out_q.step_direction,
                          out_q.step_valid, out_q.status};

endmodule

// File: tb/grid_move_history_retrace_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_move_history_retrace_core: random stream stalls,
// APB start-position writes and a cycle-accurate-free predictor of the breadcrumb stack.
// Depends on gmhr_pkg and the core itself.
module grid_move_history_retrace_core_tb;

  localparam int unsigned DEPTH      = 64;
  localparam int          QUIET_LIMIT = 1000;

  // Codes that the package leaves unnamed.
  localparam logic [2:0] DIR_NONE    = 3'd4;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // One request as it travels in tdata, func in the lowest bits.
  typedef struct packed {
    logic [2:0] dir;
    logic [1:0] fn;
  } cmd_t;

  // One result, laid out as {tlast, tdata[86:0]}.
  typedef struct packed {
    logic               last;
    logic               at_start;
    logic [15:0]        step_number;
    logic signed [15:0] to_y;
    logic signed [15:0] to_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_x;
    logic [1:0]         step_direction;
    logic               step_valid;
    logic [2:0]         status;
  } step_rec_t;

  // One breadcrumb: the move's direction, its origin and its step number.
  typedef struct packed {
    logic [15:0]        number;
    logic signed [15:0] fy;
    logic signed [15:0] fx;
    logic [1:0]         dir;
  } crumb_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted robot state.
  logic signed [15:0] start_x, start_y;
  logic signed [15:0] pos_x, pos_y;
  logic [15:0]        move_count;
  logic               has_returned;
  int                 crumb_top;
  crumb_t             crumbs [DEPTH];

  cmd_t      cmd_backlog[$];
  step_rec_t owed_steps[$];
  int        mismatch_cnt = 0;
  int        quiet_cycles = 0;
  int        idle_pct = 15;

  grid_move_history_retrace_core #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Position after one cell in direction d, one bit wider so that leaving the
  // signed 16-bit grid shows up as a disagreement of the two top bits.
  function automatic void cell_after(input logic [1:0] d, input logic signed [15:0] x,
                                     input logic signed [15:0] y,
                                     output logic signed [16:0] nx,
                                     output logic signed [16:0] ny);
    nx = x;
    ny = y;
    case (d)
      gmhr_pkg::DIR_FWD:  ny = ny + 17'sd1;
      gmhr_pkg::DIR_BWD:  ny = ny - 17'sd1;
      gmhr_pkg::DIR_LEFT: nx = nx - 17'sd1;
      default:            nx = nx + 17'sd1;
    endcase
  endfunction

  task automatic owe_step(input logic [2:0] status, input logic valid, input logic [1:0] dir,
                          input logic signed [15:0] fx, input logic signed [15:0] fy,
                          input logic signed [15:0] tx, input logic signed [15:0] ty,
                          input logic [15:0] num, input logic last);
    step_rec_t s;
    s.status         = status;
    s.step_valid     = valid;
    s.step_direction = dir;
    s.from_x         = fx;
    s.from_y         = fy;
    s.to_x           = tx;
    s.to_y           = ty;
    s.step_number    = num;
    s.at_start       = (tx == start_x) && (ty == start_y);
    s.last           = last;
    owed_steps.push_back(s);
  endtask

  // A refused request reports the unchanged position and step count.
  task automatic owe_refusal(input logic [2:0] status);
    owe_step(status, 1'b0, gmhr_pkg::DIR_FWD, pos_x, pos_y, pos_x, pos_y, move_count, 1'b1);
  endtask

  // Applies one accepted request to the predicted state and queues its results.
  task automatic predict_request(input logic [1:0] fn, input logic [2:0] dir);
    logic signed [16:0] nx, ny;
    logic [1:0]         rd;
    crumb_t             c;
    int                 k;
    case (fn)
      gmhr_pkg::FUNC_MOVE: begin
        cell_after(dir[1:0], pos_x, pos_y, nx, ny);
        if (has_returned) begin
          owe_refusal(gmhr_pkg::ST_RETURNED);
        end else if (dir[2]) begin
          owe_refusal(gmhr_pkg::ST_BAD_DIR);
        end else if (crumb_top >= DEPTH) begin
          owe_refusal(gmhr_pkg::ST_FULL);
        end else if (nx[16] != nx[15] || ny[16] != ny[15]) begin
          owe_refusal(gmhr_pkg::ST_FULL);
        end else begin
          move_count = move_count + 16'd1;
          c.dir = dir[1:0];
          c.fx = pos_x;
          c.fy = pos_y;
          c.number = move_count;
          crumbs[crumb_top] = c;
          crumb_top++;
          owe_step(gmhr_pkg::ST_OK, 1'b1, dir[1:0], pos_x, pos_y, nx[15:0], ny[15:0],
                   move_count, 1'b1);
          pos_x = nx[15:0];
          pos_y = ny[15:0];
        end
      end
      gmhr_pkg::FUNC_BACK: begin
        if (crumb_top == 0) begin
          owe_refusal(gmhr_pkg::ST_EMPTY);
        end else begin
          crumb_top--;
          c = crumbs[crumb_top];
          owe_step(gmhr_pkg::ST_OK, 1'b1, c.dir ^ 2'b01, pos_x, pos_y, c.fx, c.fy,
                   c.number, 1'b1);
          pos_x = c.fx;
          pos_y = c.fy;
        end
      end
      gmhr_pkg::FUNC_RETURN: begin
        if (has_returned) begin
          owe_refusal(gmhr_pkg::ST_RETURNED);
        end else begin
          has_returned = 1'b1;
          if (crumb_top == 0) begin
            owe_step(gmhr_pkg::ST_OK, 1'b0, gmhr_pkg::DIR_FWD, pos_x, pos_y, pos_x, pos_y,
                     move_count, 1'b1);
          end
          k = 1;
          // Newest crumb first; the reversed step wraps at the edge of the grid.
          while (crumb_top > 0) begin
            crumb_top--;
            c = crumbs[crumb_top];
            rd = c.dir ^ 2'b01;
            cell_after(rd, pos_x, pos_y, nx, ny);
            owe_step(gmhr_pkg::ST_OK, 1'b1, rd, pos_x, pos_y, nx[15:0], ny[15:0], 16'(k),
                     crumb_top == 0);
            pos_x = nx[15:0];
            pos_y = ny[15:0];
            k++;
          end
        end
      end
      default: owe_refusal(gmhr_pkg::ST_BAD_DIR);
    endcase
  endtask

  task automatic check_step(input step_rec_t got);
    step_rec_t want;
    string     bad;
    if (owed_steps.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing expected", got));
    end else begin
      want = owed_steps.pop_front();
      bad = "";
      if (got.status != want.status) bad = {bad, " status"};
      if (got.step_valid != want.step_valid) bad = {bad, " step_valid"};
      if (got.step_direction != want.step_direction) bad = {bad, " step_direction"};
      if (got.from_x != want.from_x) bad = {bad, " from_x"};
      if (got.from_y != want.from_y) bad = {bad, " from_y"};
      if (got.to_x != want.to_x) bad = {bad, " to_x"};
      if (got.to_y != want.to_y) bad = {bad, " to_y"};
      if (got.step_number != want.step_number) bad = {bad, " step_number"};
      if (got.at_start != want.at_start) bad = {bad, " at_start"};
      if (got.last != want.last) bad = {bad, " last"};
      if (bad != "") begin
        flag_mismatch($sformatf("fields%s: expected %h, got %h", bad, want, got));
      end
    end
  endtask

  // Request driver: a new request goes out once the previous one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cmd_backlog.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and predictor. Results are checked before the request taken
  // at the same edge is predicted, since that request cannot have produced them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        check_step(step_rec_t'({m_axis_tlast, m_axis_tdata[86:0]}));
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(s_axis_tdata[1:0], s_axis_tdata[4:2]);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no request or result moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] fn, input logic [2:0] dir);
    cmd_t c;
    c.fn = fn;
    c.dir = dir;
    cmd_backlog.push_back(c);
  endtask

  // Mostly valid moves and backtracks, with some invalid directions and selectors.
  task automatic queue_random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) queue_cmd(gmhr_pkg::FUNC_MOVE, 3'($urandom_range(0, 3)));
    else if (r < 85) queue_cmd(gmhr_pkg::FUNC_BACK, 3'($urandom_range(0, 7)));
    else if (r < 93) queue_cmd(gmhr_pkg::FUNC_MOVE, 3'($urandom_range(4, 7)));
    else queue_cmd(FUNC_UNUSED, 3'($urandom_range(0, 7)));
  endtask

  // Holds off until every queued request is taken and every result has come.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || owed_steps.size() != 0);
  endtask

  // APB write of one start coordinate, then a read back of the same register.
  task automatic program_start(input logic reg_idx, input logic signed [15:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {{16{v[15]}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // The write lands at this edge; the robot jumps to the new coordinate.
    if (reg_idx == gmhr_pkg::REG_START_X) begin
      start_x = v;
      pos_x = v;
    end else begin
      start_y = v;
      pos_y = v;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] != v) begin
      flag_mismatch($sformatf("register %0d read %h, expected %h", reg_idx, prdata[15:0], v));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_start(input logic signed [15:0] x, input logic signed [15:0] y);
    program_start(gmhr_pkg::REG_START_X, x);
    program_start(gmhr_pkg::REG_START_Y, y);
  endtask

  // Start coordinates near either edge of the grid half of the time.
  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return 16'sh7fff - 16'($urandom_range(0, 3));
      1:       return 16'sh8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    start_x = '0;
    start_y = '0;
    pos_x = '0;
    pos_y = '0;
    move_count = '0;
    has_returned = 1'b0;
    crumb_top = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty stack, bad selector, every invalid direction, every valid one.
    queue_cmd(gmhr_pkg::FUNC_BACK, DIR_NONE);
    queue_cmd(FUNC_UNUSED, 3'd7);
    for (int d = 4; d < 8; d++) queue_cmd(gmhr_pkg::FUNC_MOVE, 3'(d));
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_FWD);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_BWD);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_LEFT);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_RIGHT);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_FWD);
    queue_cmd(gmhr_pkg::FUNC_BACK, 3'd0);
    queue_cmd(gmhr_pkg::FUNC_BACK, 3'd7);
    // The sender stops here until the block has answered everything.
    wait_drained();

    // Corner of the grid: steps off the edge are refused, inward ones pass.
    set_start(16'sh7fff, 16'sh8000);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_RIGHT);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_BWD);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_LEFT);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_FWD);
    queue_cmd(gmhr_pkg::FUNC_BACK, 3'd0);
    queue_cmd(gmhr_pkg::FUNC_BACK, 3'd0);
    wait_drained();
    set_start(16'sh8000, 16'sh7fff);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_LEFT);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_FWD);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_RIGHT);
    queue_cmd(gmhr_pkg::FUNC_BACK, 3'd0);
    wait_drained();

    // Back-to-back move and backtrack pairs with no stalls on either side.
    set_start(16'sd0, 16'sd0);
    idle_pct = 0;
    repeat (20) begin
      queue_cmd(gmhr_pkg::FUNC_MOVE, 3'($urandom_range(0, 3)));
      queue_cmd(gmhr_pkg::FUNC_BACK, 3'($urandom_range(0, 7)));
    end
    wait_drained();
    idle_pct = 15;

    // Random walks from a fresh start position each round.
    repeat (3) begin
      set_start(pick_coord(), pick_coord());
      repeat (40) queue_random_cmd();
      wait_drained();
    end

    // Fill the stack to the top from the origin. The newest two crumbs are a left
    // and a forward move so the return starts with two steps that wrap the grid.
    if (crumb_top > DEPTH - 2) begin
      repeat (crumb_top - (DEPTH - 2)) queue_cmd(gmhr_pkg::FUNC_BACK, 3'd0);
      wait_drained();
    end
    set_start(16'sd0, 16'sd0);
    n = DEPTH - crumb_top;
    repeat (n - 2) queue_cmd(gmhr_pkg::FUNC_MOVE, 3'($urandom_range(0, 3)));
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_LEFT);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_FWD);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_RIGHT);
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_BWD);
    wait_drained();

    // Full return from the far corner.
    set_start(16'sh7fff, 16'sh8000);
    queue_cmd(gmhr_pkg::FUNC_RETURN, 3'($urandom_range(0, 7)));
    wait_drained();

    // After the return, moves and returns are refused; a backtrack finds the stack empty.
    queue_cmd(gmhr_pkg::FUNC_MOVE, gmhr_pkg::DIR_FWD);
    queue_cmd(gmhr_pkg::FUNC_MOVE, DIR_NONE);
    queue_cmd(gmhr_pkg::FUNC_RETURN, gmhr_pkg::DIR_FWD);
    queue_cmd(gmhr_pkg::FUNC_BACK, gmhr_pkg::DIR_FWD);
    queue_cmd(FUNC_UNUSED, DIR_NONE);
    repeat (20) queue_cmd(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
    wait_drained();

    // Keep the clock running to catch a stray result.
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/gmhr_pkg.sv
sv/grid_move_history_retrace_core.sv
tb/grid_move_history_retrace_core_tb.sv
